FILE: rtl/atlerp_pkg.sv
package atlerp_pkg;

  // Table geometry.
  localparam int MAX_SLICES   = 1024;
  localparam int MAX_ORBITALS = 8;
  localparam int SLICE_W      = $clog2(MAX_SLICES);
  localparam int ORB_W        = $clog2(MAX_ORBITALS);
  localparam int ROW_W        = SLICE_W - 1;
  localparam int BANK_AW      = ORB_W + ROW_W;
  localparam int BANK_DEPTH   = MAX_ORBITALS * MAX_SLICES / 2;

  // Data widths.
  localparam int DATA_W     = 32;
  localparam int BETA_W     = 31;
  localparam int SCALE_W    = 32;
  localparam int NSLICE_W   = 11;
  localparam int IN_TDATA_W = 80;
  localparam int CFG_IDX_W  = 2;

  // Result queue.
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  // Register reset values.
  localparam logic [BETA_W-1:0]   BETA_RESET   = 31'd16777216;
  localparam logic [SCALE_W-1:0]  SCALE_RESET  = 32'd67043328;
  localparam logic [NSLICE_W-1:0] NSLICE_RESET = 11'd1024;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PERIOD_BETA   = 2'd0,
    REG_INDEX_SCALE   = 2'd1,
    REG_SLICES_IN_USE = 2'd2
  } cfg_reg_e;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_QUERY = 1'b1
  } op_e;

  // Access to one bank of the sample table.
  typedef struct packed {
    logic               en;
    logic               we;
    logic [BANK_AW-1:0] addr;
    logic [DATA_W-1:0]  wdata;
  } bank_req_t;

endpackage

FILE: rtl/atlerp_bank.sv
module atlerp_bank (
  input  logic                          clk_i,
  input  atlerp_pkg::bank_req_t         req_i,
  output logic [atlerp_pkg::DATA_W-1:0] rdata_o
);
  import atlerp_pkg::*;

  logic [DATA_W-1:0] mem [BANK_DEPTH];
  logic [DATA_W-1:0] rdata_q;

  // Single port, registered read, no reset on the array.
  always_ff @(posedge clk_i) begin
    if (req_i.en) begin
      if (req_i.we) begin
        mem[req_i.addr] <= req_i.wdata;
      end else begin
        rdata_q <= mem[req_i.addr];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/atlerp_fifo.sv
module atlerp_fifo (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push_i,
  input  logic [atlerp_pkg::DATA_W-1:0] push_data_i,
  output logic                          valid_o,
  input  logic                          ready_i,
  output logic [atlerp_pkg::DATA_W-1:0] data_o
);
  import atlerp_pkg::*;

  logic [DATA_W-1:0]  store_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_q, wr_ptr_d;
  logic [FIFO_AW-1:0] rd_ptr_q, rd_ptr_d;
  logic [FIFO_AW:0]   count_q, count_d;
  logic               pop;

  // The caller never pushes into a full queue.
  assign valid_o = (count_q != '0);
  assign pop     = valid_o && ready_i;
  assign data_o  = store_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop) begin
      count_d = count_q + 1'b1;
    end else if (!push_i && pop) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      store_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

FILE: rtl/antiperiodic_table_lerp_core.sv
// Antiperiodic table lookup with linear interpolation.
//
// Requests arrive on the s_axis channel. tuser selects the operation: a
// table write stores entry_value at (orbital, slice); a query returns one
// result on m_axis. The query time is wrapped into the period when it is
// negative (flipping the sign of the answer), mirrored to beta minus time,
// scaled to a fractional slice index and interpolated between neighbors.
// The configuration channel writes beta, the index scale and the slice count
// and is always ready; the user must write it only while the block is idle.
//
// The table sits in two single-port banks, even and odd slices, so both
// neighbors are read in the same cycle. While s_axis_tready is high, one
// request is taken every cycle. Query results leave the last stage through
// the output queue to m_axis. Writes reach the banks in the same stage as
// query reads, so every query sees exactly the writes accepted before it.
// A stalled receiver fills the eight-entry result queue; s_axis_tready drops
// once eight queries are in flight or waiting, and nothing is lost.
// Reset empties the pipeline and queue and loads the default registers; the
// table contents are undefined until written.
module antiperiodic_table_lerp_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Request channel.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [31:0] query_time, [34:32] orbital, [44:35] slice, [76:45] entry_value
  input  logic [79:0] s_axis_tdata,
  // [0] operation
  input  logic [0:0]  s_axis_tuser,
  // Result channel.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [31:0] value
  output logic [31:0] m_axis_tdata,
  // Configuration write channel.
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);
  import atlerp_pkg::*;

  // Configuration registers.
  logic [BETA_W-1:0]   beta_q;
  logic [SCALE_W-1:0]  scale_q;
  logic [NSLICE_W-1:0] nslice_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beta_q   <= BETA_RESET;
      scale_q  <= SCALE_RESET;
      nslice_q <= NSLICE_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_PERIOD_BETA:   beta_q   <= cfg_data_i[BETA_W-1:0];
        REG_INDEX_SCALE:   scale_q  <= cfg_data_i[SCALE_W-1:0];
        REG_SLICES_IN_USE: nslice_q <= cfg_data_i[NSLICE_W-1:0];
        default: ;
      endcase
    end
  end

  // Credit count: queries in flight plus results waiting in the queue.
  logic [FIFO_AW:0] occ_q, occ_d;
  logic             accept;
  logic             is_query;
  logic             out_pop;

  assign s_axis_tready = (occ_q < (FIFO_AW+1)'(FIFO_DEPTH));
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign is_query      = (s_axis_tuser[0] == OP_QUERY);
  assign out_pop       = m_axis_tvalid && m_axis_tready;

  always_comb begin
    occ_d = occ_q;
    if ((accept && is_query) && !out_pop) begin
      occ_d = occ_q + 1'b1;
    end else if (!(accept && is_query) && out_pop) begin
      occ_d = occ_q - 1'b1;
    end
  end

  // Stage 1: wrap and mirror the time into a clamped distance m.
  logic signed [DATA_W-1:0] t_in;
  logic signed [DATA_W:0]   t_ext, neg_t, mirror;
  logic [DATA_W-1:0]        m_d;
  logic                     wrap_d;

  assign t_in   = $signed(s_axis_tdata[31:0]);
  assign t_ext  = {t_in[DATA_W-1], t_in};
  // After a wrap, beta - (t + beta) is just -t.
  assign neg_t  = -t_ext;
  assign mirror = $signed({2'b00, beta_q}) - t_ext;

  always_comb begin
    wrap_d = t_in[DATA_W-1];
    if (wrap_d) begin
      m_d = neg_t[DATA_W-1:0];
    end else if (mirror[DATA_W]) begin
      m_d = '0;
    end else begin
      m_d = mirror[DATA_W-1:0];
    end
  end

  logic                v1_q, op1_q, wrap1_q;
  logic [DATA_W-1:0]   m1_q, ev1_q;
  logic [ORB_W-1:0]    orb1_q;
  logic [SLICE_W-1:0]  slice1_q;

  // Stage 2: position p = m * scale, Q24.40.
  logic                v2_q, op2_q, wrap2_q;
  logic [63:0]         p2_q;
  logic [DATA_W-1:0]   ev2_q;
  logic [ORB_W-1:0]    orb2_q;
  logic [SLICE_W-1:0]  slice2_q;

  // Stage 2 combinational: slice index, clamp and bank addressing.
  logic [23:0]          lower;
  logic [23:0]          frac2;
  logic [NSLICE_W-1:0]  n_clamped;
  logic [SLICE_W-1:0]   last_idx;
  logic                 at_last2;
  logic [SLICE_W-1:0]   idx_a;
  logic [SLICE_W:0]     idx_b;
  logic [ROW_W-1:0]     even_row, odd_row;
  logic                 q2;
  bank_req_t            even_req, odd_req;
  logic [DATA_W-1:0]    even_rd, odd_rd;

  assign lower = p2_q[63:40];
  assign frac2 = p2_q[39:16];

  always_comb begin
    if (nslice_q < NSLICE_W'(2)) begin
      n_clamped = NSLICE_W'(2);
    end else if (nslice_q > NSLICE_W'(MAX_SLICES)) begin
      n_clamped = NSLICE_W'(MAX_SLICES);
    end else begin
      n_clamped = nslice_q;
    end
  end

  assign last_idx = SLICE_W'(n_clamped - 1'b1);
  assign at_last2 = (lower >= 24'(last_idx));
  assign idx_a    = at_last2 ? last_idx : lower[SLICE_W-1:0];
  // Even entry of the pair sits at row (idx+1)/2, odd entry at row idx/2.
  // Past the last slice the upper neighbor is not used, so wrap is harmless.
  assign idx_b    = {1'b0, idx_a} + 1'b1;
  assign even_row = idx_b[SLICE_W-1:1];
  assign odd_row  = idx_a[SLICE_W-1:1];
  assign q2       = v2_q && (op2_q == OP_QUERY);

  always_comb begin
    even_req       = '0;
    odd_req        = '0;
    even_req.wdata = ev2_q;
    odd_req.wdata  = ev2_q;
    if (v2_q && (op2_q == OP_WRITE)) begin
      even_req.en   = !slice2_q[0];
      even_req.we   = 1'b1;
      even_req.addr = {orb2_q, slice2_q[SLICE_W-1:1]};
      odd_req.en    = slice2_q[0];
      odd_req.we    = 1'b1;
      odd_req.addr  = {orb2_q, slice2_q[SLICE_W-1:1]};
    end else begin
      even_req.en   = q2;
      even_req.addr = {orb2_q, even_row};
      odd_req.en    = q2;
      odd_req.addr  = {orb2_q, odd_row};
    end
  end

  atlerp_bank u_even_bank (
    .clk_i   (clk_i),
    .req_i   (even_req),
    .rdata_o (even_rd)
  );

  atlerp_bank u_odd_bank (
    .clk_i   (clk_i),
    .req_i   (odd_req),
    .rdata_o (odd_rd)
  );

  // Stage 3: bank data arrives; order the pair and take the difference.
  logic               v3_q, wrap3_q, at_last3_q, par3_q;
  logic [23:0]        frac3_q;
  logic signed [DATA_W-1:0] a3, b3;
  logic signed [DATA_W:0]   diff3;

  assign a3    = par3_q ? $signed(odd_rd) : $signed(even_rd);
  assign b3    = par3_q ? $signed(even_rd) : $signed(odd_rd);
  assign diff3 = at_last3_q ? '0 : ({b3[DATA_W-1], b3} - {a3[DATA_W-1], a3});

  // Stage 4: fraction times difference.
  logic                     v4_q, wrap4_q;
  logic [23:0]              frac4_q;
  logic signed [DATA_W-1:0] a4_q;
  logic signed [DATA_W:0]   diff4_q;
  logic signed [57:0]       prod4;

  assign prod4 = $signed({1'b0, frac4_q}) * diff4_q;

  // Stage 5: add, sign, saturate; results enter the queue.
  logic                     v5_q, wrap5_q;
  logic signed [DATA_W-1:0] a5_q;
  logic signed [57:0]       prod5_q;
  logic signed [33:0]       step5;
  logic signed [34:0]       sum5;
  logic signed [35:0]       res5;
  logic [DATA_W-1:0]        value5;

  // An arithmetic shift is the floor of the division by 2^24.
  assign step5 = prod5_q[57:24];
  assign sum5  = {{3{a5_q[DATA_W-1]}}, a5_q} + {step5[33], step5};
  assign res5  = wrap5_q ? {sum5[34], sum5} : -{sum5[34], sum5};

  always_comb begin
    if (res5 > 36'sd2147483647) begin
      value5 = 32'h7FFF_FFFF;
    end else if (res5 < -36'sd2147483648) begin
      value5 = 32'h8000_0000;
    end else begin
      value5 = res5[DATA_W-1:0];
    end
  end

  atlerp_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (v5_q),
    .push_data_i (value5),
    .valid_o     (m_axis_tvalid),
    .ready_i     (m_axis_tready),
    .data_o      (m_axis_tdata)
  );

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= '0;
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      v3_q  <= 1'b0;
      v4_q  <= 1'b0;
      v5_q  <= 1'b0;
    end else begin
      occ_q <= occ_d;
      v1_q  <= accept;
      v2_q  <= v1_q;
      v3_q  <= q2;
      v4_q  <= v3_q;
      v5_q  <= v4_q;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    op1_q      <= s_axis_tuser[0];
    wrap1_q    <= wrap_d;
    m1_q       <= m_d;
    orb1_q     <= s_axis_tdata[34:32];
    slice1_q   <= s_axis_tdata[44:35];
    ev1_q      <= s_axis_tdata[76:45];

    op2_q      <= op1_q;
    wrap2_q    <= wrap1_q;
    p2_q       <= 64'(m1_q) * 64'(scale_q);
    orb2_q     <= orb1_q;
    slice2_q   <= slice1_q;
    ev2_q      <= ev1_q;

    wrap3_q    <= wrap2_q;
    at_last3_q <= at_last2;
    par3_q     <= idx_a[0];
    frac3_q    <= frac2;

    wrap4_q    <= wrap3_q;
    frac4_q    <= frac3_q;
    a4_q       <= a3;
    diff4_q    <= diff3;

    wrap5_q    <= wrap4_q;
    a5_q       <= a4_q;
    prod5_q    <= prod4;
  end

endmodule

FILE: tb/sv/antiperiodic_table_lerp_core_tb.sv
// Self-checking testbench for the antiperiodic table interpolation core.
//
// An initial block builds requests into a queue and runs the test phase by
// phase. A clocked driver presents the queued requests on s_axis. When a
// request is accepted, the driver updates a shadow copy of the sample table
// (for a write) or computes the interpolated value (for a query) and queues it.
// A clocked monitor takes results from m_axis and compares each one with the
// oldest queued value. Registers change only between phases, once the core
// has drained.
module antiperiodic_table_lerp_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import atlerp_pkg::*;

  typedef struct {
    op_e         op;
    logic [31:0] qtime;
    logic [2:0]  orb;
    logic [9:0]  slc;
    logic [31:0] val;
  } lut_req_t;

  localparam longint VAL_MAX = 64'sd2147483647;
  localparam longint VAL_MIN = -64'sd2147483648;

  // Clock, reset and the ports of the core. Every input starts at a known value.
  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // [31:0] query_time, [34:32] orbital, [44:35] slice, [76:45] entry_value
  logic [79:0] s_axis_tdata  = '0;
  // [0] operation
  logic [0:0]  s_axis_tuser  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // [31:0] value
  logic [31:0] m_axis_tdata;
  logic        cfg_valid_i   = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i   = '0;
  logic [31:0] cfg_data_i    = '0;

  // Shadow state. The generator uses the same register copies because the
  // registers never change while requests are outstanding.
  logic signed [31:0] lut_shadow [MAX_ORBITALS][MAX_SLICES];
  bit                 loaded     [MAX_ORBITALS][MAX_SLICES];
  logic [BETA_W-1:0]   beta_reg   = BETA_RESET;
  logic [SCALE_W-1:0]  scale_reg  = SCALE_RESET;
  logic [NSLICE_W-1:0] nslice_reg = NSLICE_RESET;

  lut_req_t    req_queue[$];
  logic [31:0] pending_values[$];
  logic [31:0] exp_value;
  int          error_count     = 0;
  int          sender_idle_pct = 0;
  int          recv_idle_pct   = 0;

  always #2 clk_i = ~clk_i;

  antiperiodic_table_lerp_core u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // The slice count register is honored only within [2, MAX_SLICES].
  function automatic longint eff_slices();
    longint n;
    n = longint'(nslice_reg);
    if (n < 2) n = 2;
    if (n > MAX_SLICES) n = MAX_SLICES;
    return n;
  endfunction

  // Maps a query time to the lower slice, the last slice in use and the Q0.24
  // fraction. A negative time is wrapped by one period, which flags the sign
  // flip. The mirrored time beta - t is held within [0, 2^32] before scaling.
  function automatic void locate_slice(input logic [31:0] t_bits, output longint lower,
                                       output longint last, output longint frac,
                                       output bit wrapped);
    longint     beta_l;
    longint     t;
    longint     m;
    logic [64:0] pos;
    beta_l  = longint'(beta_reg);
    t       = longint'($signed(t_bits));
    wrapped = (t < 0);
    if (wrapped) t = t + beta_l;
    m = beta_l - t;
    if (m < 0) m = 0;
    if (m > 64'sh1_0000_0000) m = 64'sh1_0000_0000;
    // Q8.24 times Q16.16 gives a Q24.40 slice position.
    pos   = {1'b0, m} * {33'd0, scale_reg};
    lower = longint'(pos >> 40);
    frac  = longint'(pos[39:16]);
    last  = eff_slices() - 1;
  endfunction

  function automatic logic [31:0] interp_value(logic [31:0] t_bits, logic [2:0] orb);
    longint lower, last, frac, a, b, v;
    bit     wrapped;
    locate_slice(t_bits, lower, last, frac, wrapped);
    // At or past the last slice the sample is taken as it is, with no
    // neighbor beyond it; time zero lands here under the reset registers.
    if (lower >= last) begin
      v = longint'(lut_shadow[orb][last]);
    end else begin
      a = longint'(lut_shadow[orb][lower]);
      b = longint'(lut_shadow[orb][lower + 1]);
      v = a + ((frac * (b - a)) >>> 24);
    end
    // The answer is negated unless the time was wrapped; negating the most
    // negative value saturates.
    if (!wrapped) v = -v;
    if (v > VAL_MAX) v = VAL_MAX;
    if (v < VAL_MIN) v = VAL_MIN;
    return v[31:0];
  endfunction

  // Applies one accepted request to the shadow state.
  function automatic void apply_request(lut_req_t r);
    if (r.op == OP_WRITE) begin
      lut_shadow[r.orb][r.slc] = r.val;
    end else begin
      pending_values.push_back(interp_value(r.qtime, r.orb));
    end
  endfunction

  // Driver. A request stays on the bus until it is accepted; a free slot is
  // left empty at the sender idle rate.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) apply_request(req_queue.pop_front());
      if (!s_axis_tvalid || s_axis_tready) begin
        if (req_queue.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {3'b000, req_queue[0].val, req_queue[0].slc,
                            req_queue[0].orb, req_queue[0].qtime};
          s_axis_tuser  <= req_queue[0].op;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor. Every result must match the oldest outstanding query.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_values.size() == 0) begin
          error_count++;
          $error("value: no query outstanding, actual %0d", $signed(m_axis_tdata));
        end else begin
          exp_value = pending_values.pop_front();
          if (m_axis_tdata !== exp_value) begin
            error_count++;
            $error("value mismatch: expected %0d, actual %0d",
                   $signed(exp_value), $signed(m_axis_tdata));
          end
        end
      end
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Sample values lean toward the extremes so the interpolation sees the
  // widest differences between neighbors.
  function automatic logic [31:0] rand_sample();
    case ($urandom_range(9))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2, 3:    return $urandom_range(2**25) - 2**24;
      default: return $urandom;
    endcase
  endfunction

  // Most times fall within one period either side of zero, where the index
  // math is meaningful; the rest are edges and raw 32-bit patterns.
  function automatic logic [31:0] rand_time();
    longint b, t;
    b = longint'(beta_reg);
    case ($urandom_range(9))
      0: begin
        case ($urandom_range(6))
          0:       t = 0;
          1:       t = b;
          2:       t = -b;
          3:       t = b - 1;
          4:       t = 1 - b;
          5:       t = 1;
          default: t = -1;
        endcase
      end
      1, 2:    t = longint'($signed($urandom));
      default: t = (longint'($urandom) % (2 * b + 1)) - b;
    endcase
    return t[31:0];
  endfunction

  function automatic void push_write(logic [2:0] orb, logic [9:0] slc, logic [31:0] val);
    req_queue.push_back('{OP_WRITE, $urandom, orb, slc, val});
    loaded[orb][slc] = 1'b1;
  endfunction

  function automatic void fill_entry(logic [2:0] orb, longint idx);
    if (!loaded[orb][idx]) push_write(orb, idx[9:0], rand_sample());
  endfunction

  // A query only reads entries that have been written; any missing neighbor
  // is loaded just ahead of it.
  function automatic void push_query(logic [31:0] t, logic [2:0] orb);
    longint lower, last, frac;
    bit     wrapped;
    locate_slice(t, lower, last, frac, wrapped);
    if (lower >= last) begin
      fill_entry(orb, last);
    end else begin
      fill_entry(orb, lower);
      fill_entry(orb, lower + 1);
    end
    req_queue.push_back('{OP_QUERY, t, orb, 10'($urandom), $urandom});
  endfunction

  function automatic void random_requests(int count);
    longint last;
    last = eff_slices() - 1;
    repeat (count) begin
      if ($urandom_range(99) < 35) begin
        push_write(3'($urandom_range(7)),
                   10'(($urandom_range(3) == 0) ? $urandom_range(1023)
                                                : $urandom_range(32'(last))),
                   rand_sample());
      end else begin
        push_query(rand_time(), 3'($urandom_range(7)));
      end
    end
  endfunction

  // Index scale that maps one period onto the slices in use, capped at 32 bits.
  function automatic logic [31:0] fit_scale(longint beta, longint n);
    longint s;
    if (n < 2) n = 2;
    if (n > MAX_SLICES) n = MAX_SLICES;
    s = ((n - 1) <<< 40) / beta;
    if (s > 64'sh0_FFFF_FFFF) s = 64'sh0_FFFF_FFFF;
    return s[31:0];
  endfunction

  // Waits until every queued request is accepted and every result is back,
  // then lets the pipeline settle past any trailing writes.
  task automatic drain();
    while (req_queue.size() != 0 || pending_values.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic cfg_write(cfg_reg_e idx, logic [31:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!(cfg_valid_i && cfg_ready_o));
    cfg_valid_i <= 1'b0;
    case (idx)
      REG_PERIOD_BETA:   beta_reg   = data[BETA_W-1:0];
      REG_INDEX_SCALE:   scale_reg  = data;
      REG_SLICES_IN_USE: nslice_reg = data[NSLICE_W-1:0];
      default: ;
    endcase
  endtask

  // Bits above each register's width are randomized; the core must drop them.
  task automatic configure(logic [30:0] beta, logic [10:0] nslice, logic [31:0] scale);
    drain();
    cfg_write(REG_PERIOD_BETA, {1'($urandom), beta});
    cfg_write(REG_INDEX_SCALE, scale);
    cfg_write(REG_SLICES_IN_USE, {21'($urandom), nslice});
  endtask

  task automatic set_idling(int sender_pct, int recv_pct);
    sender_idle_pct = sender_pct;
    recv_idle_pct   = recv_pct;
  endtask

  initial begin
    logic [30:0] beta;
    logic [10:0] nslice;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part under the reset registers (beta 1.0, 1024 slices).
    set_idling(20, 59);
    push_write(3'd0, 10'd0, 32'h8000_0000);
    push_write(3'd0, 10'd1, 32'h7FFF_FFFF);
    push_write(3'd0, 10'd511, 32'h8000_0000);
    push_write(3'd0, 10'd512, 32'h7FFF_FFFF);
    push_write(3'd0, 10'd1023, 32'h8000_0000);
    push_write(3'd7, 10'd1023, 32'h7FFF_FFFF);
    push_write(3'd7, 10'd0, 32'h0000_0000);
    push_query(32'h0000_0000, 3'd0);  // time zero: last slice, negation saturates
    push_query(32'h0100_0000, 3'd0);  // time beta: slice 0 exactly
    push_query(32'hFF00_0000, 3'd0);  // minus beta: wrapped, last slice
    push_query(32'h00FF_FFFF, 3'd0);  // just inside slice 0, widest difference
    push_query(32'h7FFF_FFFF, 3'd0);  // above beta: mirrored time held at zero
    push_query(32'h8000_0000, 3'd0);  // most negative time: index far past the end
    push_query(32'h0080_0000, 3'd0);  // halfway between slices 511 and 512
    push_query(32'h0000_0000, 3'd7);
    push_query(32'hFFFF_FFFF, 3'd7);  // wrapped just below zero

    // Extremes: shortest period, two slices, largest scale.
    configure(31'd1, 11'd2, 32'hFFFF_FFFF);
    random_requests(100);

    beta = 31'h7FFF_FFFF;
    configure(beta, 11'd1024, fit_scale(longint'(beta), 1024));
    random_requests(100);

    beta   = 31'($urandom_range(2**30, 2**24));
    nslice = 11'($urandom_range(32, 2));
    configure(beta, nslice, fit_scale(longint'(beta), longint'(nslice)));
    random_requests(100);

    // Receiver now idles less than the sender.
    set_idling(59, 20);
    // Slice count below range is taken as two; a zero scale pins slice 0.
    configure(31'h0100_0000, 11'd0, 32'd0);
    random_requests(100);

    // Slice count above range is taken as MAX_SLICES.
    beta = 31'($urandom_range(2**31 - 1, 2**20));
    configure(beta, 11'd2047, fit_scale(longint'(beta), longint'(MAX_SLICES)));
    random_requests(100);

    // The sender holds off halfway until all results are back.
    beta   = 31'($urandom_range(2**31 - 1, 2**22));
    nslice = 11'($urandom_range(1024, 2));
    configure(beta, nslice, fit_scale(longint'(beta), longint'(nslice)));
    random_requests(50);
    drain();
    random_requests(50);

    // No idling on either side.
    set_idling(0, 0);
    beta   = 31'($urandom_range(2**28, 2**16));
    nslice = 11'($urandom_range(16, 3));
    configure(beta, nslice,
              fit_scale(longint'(beta), longint'(nslice)) ^ 32'($urandom_range(255)));
    random_requests(100);

    configure(BETA_RESET, NSLICE_RESET, SCALE_RESET);
    random_requests(100);

    drain();
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
